>>> hw/rtl/chtp_pkg.sv
// Shared types, constants and status codes for the credential hash table probe unit.
// Used by the controller, the datapath, the top level and the port checker.
package chtp_pkg;

    // Default parameter values
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int KEY_BYTES_DEF   = 16;
    localparam int PROBE_LIMIT_DEF = 16;

    // Fixed field widths
    localparam int KEY_W       = 128;
    localparam int DIGEST_W    = 160;
    localparam int S_TDATA_W   = KEY_W + DIGEST_W;
    localparam int STATUS_W    = 3;
    localparam int M_TDATA_W   = 8;
    localparam int ADDR_W_MAX  = 10;
    localparam int BYTE_IDX_W  = 4;

    // Multiplicative hash constant
    localparam logic [31:0] MUL_CONST = 32'd2654435769;

    // Remainder unit: reciprocal product, quotient bits, subtract
    localparam int MOD_STEPS = 3;

    // Command codes on s_tuser
    localparam logic CMD_REGISTER = 1'b0;
    localparam logic CMD_CHECK    = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ACCEPT   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REJECT   = 3'd4;

    // One table row
    typedef struct packed {
        logic                slot_used;
        logic [KEY_W-1:0]    key;
        logic [DIGEST_W-1:0] digest;
    } entry_t;

    // Controller to datapath
    typedef struct packed {
        logic                  load_item;
        logic                  hash_step;
        logic                  mod_step;
        logic                  probe_adv;
        logic                  rd_en;
        logic                  wr_insert;
        logic                  wr_replace;
        logic                  clr_wr;
        logic                  res_load;
        logic [STATUS_W-1:0]   res_code;
        logic                  out_load;
        logic [BYTE_IDX_W-1:0] byte_idx;
        logic [ADDR_W_MAX-1:0] clr_addr;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic slot_used;
        logic key_match;
        logic digest_match;
        logic is_check;
    } stat_t;

endpackage

>>> hw/rtl/chtp_datapath.sv
// Datapath of the probe unit: item registers, hash multiplier, remainder unit,
// probe address stepping and the table memory. Depends on chtp_pkg.
module chtp_datapath #(
    parameter int TABLE_DEPTH = chtp_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_BYTES   = chtp_pkg::KEY_BYTES_DEF
) (
    input  logic                             aclk,
    input  chtp_pkg::cmd_t                   cmd,
    input  logic                             s_tuser,
    input  logic [chtp_pkg::S_TDATA_W-1:0]   s_tdata,
    output chtp_pkg::stat_t                  stat,
    output logic [chtp_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int SW = $clog2(TABLE_DEPTH);
    localparam int RW = SW + 1;
    localparam logic [RW-1:0] DEPTH_R = RW'(TABLE_DEPTH);
    localparam logic [RW-1:0] ODD0    = RW'(3 % TABLE_DEPTH);
    localparam int KW = chtp_pkg::KEY_W;
    localparam int DW = chtp_pkg::DIGEST_W;
    // ceil(2^(32+SW) / TABLE_DEPTH), exact quotient for every 32-bit hash
    localparam logic [63:0] RECIP    = ((64'd1 << (32 + SW)) + 64'(TABLE_DEPTH) - 64'd1)
                                       / 64'(TABLE_DEPTH);
    localparam logic [31:0] RECIP_LO = RECIP[31:0];
    localparam logic        RECIP_HI = RECIP[32];

    logic                  is_check_reg;
    logic [KW-1:0]         key_reg;
    logic [DW-1:0]         digest_reg;
    logic [31:0]           hash_reg, hash_next;
    logic [RW-1:0]         rem_reg, rem_next;
    logic [RW-1:0]         sq_reg, sq_next;
    logic [RW-1:0]         odd_reg, odd_next;
    logic [63:0]           prod_reg, prod_next;
    logic [RW-1:0]         quot_reg, quot_next;
    chtp_pkg::entry_t      rd_reg;
    logic [chtp_pkg::STATUS_W-1:0] res_reg;
    logic [chtp_pkg::STATUS_W-1:0] out_reg;

    chtp_pkg::entry_t      mem [TABLE_DEPTH];
    chtp_pkg::entry_t      wr_data;
    logic [SW-1:0]         slot;
    logic [SW-1:0]         wr_addr;
    logic                  wr_en;

    logic [7:0]            hash_byte;
    logic [31:0]           hash_sum;
    logic                  key_match;

    assign slot      = rem_reg[SW-1:0];
    assign hash_byte = key_reg[{cmd.byte_idx, 3'b000} +: 8];
    assign hash_sum  = hash_reg + {{24{hash_byte[7]}}, hash_byte};

    // Hash held during the mod steps: product first, then quotient low bits
    always_comb begin
        logic [64:0] wide_sum;
        prod_next = 64'(hash_reg) * 64'(RECIP_LO);
        wide_sum  = {1'b0, prod_reg} + (RECIP_HI ? {1'b0, hash_reg, 32'd0} : 65'd0);
        quot_next = wide_sum[32 + SW +: RW];
    end

    always_comb begin
        logic [RW-1:0] t;
        t         = '0;
        hash_next = hash_reg;
        rem_next  = rem_reg;
        sq_next   = sq_reg;
        odd_next  = odd_reg;
        if (cmd.load_item) begin
            hash_next = '0;
            rem_next  = '0;
            sq_next   = RW'(1);
            odd_next  = ODD0;
        end else if (cmd.hash_step) begin
            hash_next = hash_sum * chtp_pkg::MUL_CONST;
        end else if (cmd.mod_step) begin
            // remainder fits in RW bits, so only the low bits take part
            rem_next = hash_reg[RW-1:0] - quot_reg * DEPTH_R;
        end else if (cmd.probe_adv) begin
            // slot += (p+1)^2, then the square advances by the next odd number
            t = rem_reg + sq_reg;
            rem_next = (t >= DEPTH_R) ? t - DEPTH_R : t;
            t = sq_reg + odd_reg;
            sq_next = (t >= DEPTH_R) ? t - DEPTH_R : t;
            t = odd_reg + RW'(2);
            odd_next = (t >= DEPTH_R) ? t - DEPTH_R : t;
        end
    end

    // Keys match up to and including the first zero byte
    always_comb begin
        logic [7:0] a_byte;
        logic [7:0] b_byte;
        logic       alive;
        key_match = 1'b1;
        alive     = 1'b1;
        for (int i = 0; i < KEY_BYTES; i++) begin
            a_byte = key_reg[i*8 +: 8];
            b_byte = rd_reg.key[i*8 +: 8];
            if (alive && (a_byte != b_byte)) begin
                key_match = 1'b0;
            end
            alive = alive && (a_byte == b_byte) && (a_byte != 8'd0);
        end
    end

    always_comb begin
        wr_data.slot_used = ~cmd.clr_wr;
        wr_data.key       = cmd.wr_replace ? rd_reg.key : key_reg;
        wr_data.digest    = digest_reg;
    end

    assign wr_en   = cmd.clr_wr | cmd.wr_insert | cmd.wr_replace;
    assign wr_addr = cmd.clr_wr ? cmd.clr_addr[SW-1:0] : slot;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_reg <= mem[slot];
        end
    end

    always_ff @(posedge aclk) begin
        hash_reg <= hash_next;
        rem_reg  <= rem_next;
        sq_reg   <= sq_next;
        odd_reg  <= odd_next;
        prod_reg <= prod_next;
        quot_reg <= quot_next;
        if (cmd.load_item) begin
            is_check_reg <= s_tuser;
            key_reg      <= s_tdata[KW-1:0];
            digest_reg   <= s_tdata[KW +: DW];
        end
        if (cmd.res_load) begin
            res_reg <= cmd.res_code;
        end
        if (cmd.out_load) begin
            out_reg <= res_reg;
        end
    end

    assign stat.slot_used    = rd_reg.slot_used;
    assign stat.key_match    = key_match;
    assign stat.digest_match = (rd_reg.digest == digest_reg);
    assign stat.is_check     = is_check_reg;

    assign m_tdata = {{(chtp_pkg::M_TDATA_W - chtp_pkg::STATUS_W){1'b0}}, out_reg};

endmodule

>>> hw/rtl/chtp_ctrl.sv
// Controller state machine of the probe unit: clearing pass, hash, remainder,
// probe loop and result handoff. Depends on chtp_pkg.
module chtp_ctrl #(
    parameter int TABLE_DEPTH = chtp_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_BYTES   = chtp_pkg::KEY_BYTES_DEF,
    parameter int PROBE_LIMIT = chtp_pkg::PROBE_LIMIT_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  chtp_pkg::stat_t   stat,
    output chtp_pkg::cmd_t    cmd
);

    localparam int SW = $clog2(TABLE_DEPTH);
    localparam int PW = $clog2(PROBE_LIMIT + 1);
    localparam int MW = $clog2(chtp_pkg::MOD_STEPS);
    localparam int BW = chtp_pkg::BYTE_IDX_W;
    localparam int AW = chtp_pkg::ADDR_W_MAX;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_MOD   = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_CMP   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [BW-1:0] byte_reg, byte_next;
    logic [MW-1:0] mod_reg, mod_next;
    logic [PW-1:0] probe_reg, probe_next;
    logic [SW-1:0] clr_reg, clr_next;
    logic          m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        byte_next    = byte_reg;
        mod_next     = mod_reg;
        probe_next   = probe_reg;
        clr_next     = clr_reg;
        cmd          = '0;
        cmd.byte_idx = byte_reg;
        cmd.clr_addr = AW'(clr_reg);
        m_valid_next = m_valid_reg & ~m_tready;

        case (state_reg)
            S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (clr_reg == SW'(TABLE_DEPTH - 1)) begin
                    state_next = S_IDLE;
                end else begin
                    clr_next = clr_reg + SW'(1);
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    byte_next     = '0;
                    mod_next      = '0;
                    probe_next    = '0;
                    state_next    = S_HASH;
                end
            end
            S_HASH: begin
                cmd.hash_step = 1'b1;
                if (byte_reg == BW'(KEY_BYTES - 1)) begin
                    state_next = S_MOD;
                end else begin
                    byte_next = byte_reg + BW'(1);
                end
            end
            S_MOD: begin
                cmd.mod_step = 1'b1;
                if (mod_reg == MW'(chtp_pkg::MOD_STEPS - 1)) begin
                    state_next = S_READ;
                end else begin
                    mod_next = mod_reg + MW'(1);
                end
            end
            S_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = S_CMP;
            end
            S_CMP: begin
                if (!stat.slot_used) begin
                    cmd.res_load  = 1'b1;
                    cmd.res_code  = stat.is_check ? chtp_pkg::ST_REJECT
                                                  : chtp_pkg::ST_INSERTED;
                    cmd.wr_insert = ~stat.is_check;
                    state_next    = S_DONE;
                end else if (stat.key_match) begin
                    cmd.res_load   = 1'b1;
                    cmd.wr_replace = ~stat.is_check;
                    if (!stat.is_check) begin
                        cmd.res_code = chtp_pkg::ST_REPLACED;
                    end else if (stat.digest_match) begin
                        cmd.res_code = chtp_pkg::ST_ACCEPT;
                    end else begin
                        cmd.res_code = chtp_pkg::ST_REJECT;
                    end
                    state_next = S_DONE;
                end else if (probe_reg == PW'(PROBE_LIMIT - 1)) begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = stat.is_check ? chtp_pkg::ST_REJECT
                                                 : chtp_pkg::ST_FULL;
                    state_next   = S_DONE;
                end else begin
                    cmd.probe_adv = 1'b1;
                    probe_next    = probe_reg + PW'(1);
                    state_next    = S_READ;
                end
            end
            S_DONE: begin
                // hold the result until the output word is free
                if (!m_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            byte_reg    <= '0;
            mod_reg     <= '0;
            probe_reg   <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            byte_reg    <= byte_next;
            mod_reg     <= mod_next;
            probe_reg   <= probe_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;

endmodule

>>> hw/rtl/credential_hash_table_probe_unit.sv
// Top level of the credential hash table probe unit: controller plus datapath.
// Depends on chtp_pkg, chtp_ctrl and chtp_datapath.
//
// Each input word is a register (s_tuser 0) or check (s_tuser 1) command with
// a login key and a precomputed password digest; each produces one status word.
// After the input word is accepted, the key bytes go one by one through the
// 32-bit hash multiplier, then the remainder unit (reciprocal product, quotient,
// subtract), then a read and a compare per probe. Items are handled one at a
// time; the next item is taken while a finished status word still waits on the
// output. After reset a clearing pass empties the table before the first item.
module credential_hash_table_probe_unit #(
    parameter int TABLE_DEPTH = chtp_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_BYTES   = chtp_pkg::KEY_BYTES_DEF,
    parameter int PROBE_LIMIT = chtp_pkg::PROBE_LIMIT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // key_low[63:0], key_high[127:64], digest_a[191:128], digest_b[255:192],
    // digest_c[287:256]
    input  logic [chtp_pkg::S_TDATA_W-1:0]   s_tdata,
    // command
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status[2:0], zeros above
    output logic [chtp_pkg::M_TDATA_W-1:0]   m_tdata
);

    chtp_pkg::cmd_t  ctrl_cmd;
    chtp_pkg::stat_t dp_stat;

    chtp_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BYTES   (KEY_BYTES),
        .PROBE_LIMIT (PROBE_LIMIT)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (dp_stat),
        .cmd      (ctrl_cmd)
    );

    chtp_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BYTES   (KEY_BYTES)
    ) u_datapath (
        .aclk    (aclk),
        .cmd     (ctrl_cmd),
        .s_tuser (s_tuser),
        .s_tdata (s_tdata),
        .stat    (dp_stat),
        .m_tdata (m_tdata)
    );

endmodule

>>> hw/rtl/chtp_checker.sv
// Port-level checker for the credential hash table probe unit, bound to the top.
// Depends on chtp_pkg.
module chtp_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [chtp_pkg::M_TDATA_W-1:0] m_tdata
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] pend_reg, pend_next;

    assign in_acc  = s_tvalid & s_tready;
    assign out_acc = m_tvalid & m_tready;

    always_comb begin
        pend_next = pend_reg;
        if (in_acc && !out_acc) begin
            pend_next = pend_reg + 2'd1;
        end else if (out_acc && !in_acc) begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    // A stalled status word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("status word changed while stalled");

    // One item at a time: input closes right after a word is taken
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> !s_tready)
        else $error("input stayed open after accepting a word");

    // Status is a defined code with zero padding
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:3] == 5'd0) &&
                     (m_tdata[2:0] == chtp_pkg::ST_INSERTED ||
                      m_tdata[2:0] == chtp_pkg::ST_REPLACED ||
                      m_tdata[2:0] == chtp_pkg::ST_FULL ||
                      m_tdata[2:0] == chtp_pkg::ST_ACCEPT ||
                      m_tdata[2:0] == chtp_pkg::ST_REJECT))
        else $error("undefined status code");

    // No result without an item, at most one item in work plus one waiting
    a_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg != 2'd3) && (!m_tvalid || pend_reg != 2'd0))
        else $error("results out of step with accepted items");

endmodule

bind credential_hash_table_probe_unit chtp_checker u_chtp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
